// File: rtl/rsha_pkg.sv
// rsha_pkg: shared types, resonance codes, term source codes and the
// per-resonance coefficient table of the helicity amplitude block.
// depends on nothing; used by rsha_front, rsha_queue, rsha_back, rsha_chk, the top level and the testbench.
package rsha_pkg;

  localparam int FRAC_BITS = 24;
  localparam int COEF_BITS = 28;
  localparam int COEF_W    = 33;
  localparam int RES_W     = 5;
  localparam int SRC_W     = 5;
  localparam int NUM_RES   = 18;
  localparam int NUM_SRC   = 17;
  localparam int NUM_AMP   = 6;
  localparam int NUM_SLOT  = 18;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [SRC_W-1:0]         src_t;
  typedef logic [RES_W-1:0]         res_t;

  typedef struct packed {
    coef_t coef;
    src_t  src;
  } term_sel_t;

  typedef term_sel_t [NUM_SLOT-1:0] row_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // term sources
  localparam src_t X_RM   = 5'd0;
  localparam src_t X_RP   = 5'd1;
  localparam src_t X_TM   = 5'd2;
  localparam src_t X_TP   = 5'd3;
  localparam src_t X_C    = 5'd4;
  localparam src_t X_B    = 5'd5;
  localparam src_t X_LRM  = 5'd6;
  localparam src_t X_LRP  = 5'd7;
  localparam src_t X_LTM  = 5'd8;
  localparam src_t X_LTP  = 5'd9;
  localparam src_t X_LC   = 5'd10;
  localparam src_t X_LS   = 5'd11;
  localparam src_t X_LB   = 5'd12;
  localparam src_t X_L2RM = 5'd13;
  localparam src_t X_L2RP = 5'd14;
  localparam src_t X_L2C  = 5'd15;
  localparam src_t X_L2S  = 5'd16;

  // resonance codes
  localparam res_t R_P33_1232 = 5'd0;
  localparam res_t R_S11_1535 = 5'd1;
  localparam res_t R_D13_1520 = 5'd2;
  localparam res_t R_S11_1650 = 5'd3;
  localparam res_t R_D13_1700 = 5'd4;
  localparam res_t R_D15_1675 = 5'd5;
  localparam res_t R_S31_1620 = 5'd6;
  localparam res_t R_D33_1700 = 5'd7;
  localparam res_t R_P11_1440 = 5'd8;
  localparam res_t R_P33_1600 = 5'd9;
  localparam res_t R_P13_1720 = 5'd10;
  localparam res_t R_F15_1680 = 5'd11;
  localparam res_t R_P31_1910 = 5'd12;
  localparam res_t R_P33_1920 = 5'd13;
  localparam res_t R_F35_1905 = 5'd14;
  localparam res_t R_F37_1950 = 5'd15;
  localparam res_t R_P11_1710 = 5'd16;
  localparam res_t R_F17_1970 = 5'd17;

  // first slot of each amplitude in a row
  localparam int A_M1 = 0;
  localparam int A_P1 = 3;
  localparam int A_M3 = 6;
  localparam int A_P3 = 9;
  localparam int A_ZM = 12;
  localparam int A_ZP = 15;

  // bitwise integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] bt;
    x  = v;
    r  = '0;
    bt = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // sqrt(n/d) in Q4.28
  localparam coef_t K2_1   = coef_t'(isqrt64((64'd2 << 56) / 64'd1));
  localparam coef_t K6_1   = coef_t'(isqrt64((64'd6 << 56) / 64'd1));
  localparam coef_t K8_1   = coef_t'(isqrt64((64'd8 << 56) / 64'd1));
  localparam coef_t K12_1  = coef_t'(isqrt64((64'd12 << 56) / 64'd1));
  localparam coef_t K8_3   = coef_t'(isqrt64((64'd8 << 56) / 64'd3));
  localparam coef_t K24_1  = coef_t'(isqrt64((64'd24 << 56) / 64'd1));
  localparam coef_t K16_3  = coef_t'(isqrt64((64'd16 << 56) / 64'd3));
  localparam coef_t K18_1  = coef_t'(isqrt64((64'd18 << 56) / 64'd1));
  localparam coef_t K1_6   = coef_t'(isqrt64((64'd1 << 56) / 64'd6));
  localparam coef_t K2_3   = coef_t'(isqrt64((64'd2 << 56) / 64'd3));
  localparam coef_t K1_30  = coef_t'(isqrt64((64'd1 << 56) / 64'd30));
  localparam coef_t K9_10  = coef_t'(isqrt64((64'd9 << 56) / 64'd10));
  localparam coef_t K2_15  = coef_t'(isqrt64((64'd2 << 56) / 64'd15));
  localparam coef_t K3_10  = coef_t'(isqrt64((64'd3 << 56) / 64'd10));
  localparam coef_t K3_5   = coef_t'(isqrt64((64'd3 << 56) / 64'd5));
  localparam coef_t K6_5   = coef_t'(isqrt64((64'd6 << 56) / 64'd5));
  localparam coef_t K3_1   = coef_t'(isqrt64((64'd3 << 56) / 64'd1));
  localparam coef_t K3_2   = coef_t'(isqrt64((64'd3 << 56) / 64'd2));
  localparam coef_t K1_3   = coef_t'(isqrt64((64'd1 << 56) / 64'd3));
  localparam coef_t K9_2   = coef_t'(isqrt64((64'd9 << 56) / 64'd2));
  localparam coef_t K25_12 = coef_t'(isqrt64((64'd25 << 56) / 64'd12));
  localparam coef_t K3_4   = coef_t'(isqrt64((64'd3 << 56) / 64'd4));
  localparam coef_t K25_3  = coef_t'(isqrt64((64'd25 << 56) / 64'd3));
  localparam coef_t K1_2   = coef_t'(isqrt64((64'd1 << 56) / 64'd2));
  localparam coef_t K27_10 = coef_t'(isqrt64((64'd27 << 56) / 64'd10));
  localparam coef_t K5_3   = coef_t'(isqrt64((64'd5 << 56) / 64'd3));
  localparam coef_t K125_3 = coef_t'(isqrt64((64'd125 << 56) / 64'd3));
  localparam coef_t K9_5   = coef_t'(isqrt64((64'd9 << 56) / 64'd5));
  localparam coef_t K5_2   = coef_t'(isqrt64((64'd5 << 56) / 64'd2));
  localparam coef_t K18_5  = coef_t'(isqrt64((64'd18 << 56) / 64'd5));
  localparam coef_t K1_15  = coef_t'(isqrt64((64'd1 << 56) / 64'd15));
  localparam coef_t K4_15  = coef_t'(isqrt64((64'd4 << 56) / 64'd15));
  localparam coef_t K20_3  = coef_t'(isqrt64((64'd20 << 56) / 64'd3));
  localparam coef_t K1_5   = coef_t'(isqrt64((64'd1 << 56) / 64'd5));
  localparam coef_t K1_35  = coef_t'(isqrt64((64'd1 << 56) / 64'd35));
  localparam coef_t K18_35 = coef_t'(isqrt64((64'd18 << 56) / 64'd35));
  localparam coef_t K4_35  = coef_t'(isqrt64((64'd4 << 56) / 64'd35));
  localparam coef_t K6_35  = coef_t'(isqrt64((64'd6 << 56) / 64'd35));
  localparam coef_t K2_7   = coef_t'(isqrt64((64'd2 << 56) / 64'd7));
  localparam coef_t K24_35 = coef_t'(isqrt64((64'd24 << 56) / 64'd35));
  localparam coef_t K3_35  = coef_t'(isqrt64((64'd3 << 56) / 64'd35));
  localparam coef_t K1_7   = coef_t'(isqrt64((64'd1 << 56) / 64'd7));

  function automatic term_sel_t ts(input coef_t c, input src_t s);
    return '{coef: c, src: s};
  endfunction

  // coefficient and term source for all 18 slots of one resonance
  function automatic row_t amp_row(input res_t res);
    row_t r;
    r = '0;
    unique case (res)
      R_P33_1232: begin
        r[A_M1] = ts(K2_1, X_RM);   r[A_P1] = ts(-K2_1, X_RP);
        r[A_M3] = ts(K6_1, X_RM);   r[A_P3] = ts(-K6_1, X_RP);
        r[A_ZM] = ts(-K8_1, X_C);   r[A_ZP] = ts(-K8_1, X_C);
      end
      R_S11_1535: begin
        r[A_M1] = ts(K12_1, X_TM);  r[A_M1+1] = ts(K8_3, X_LRM);
        r[A_P1] = ts(-K12_1, X_TP); r[A_P1+1] = ts(-K8_3, X_LRP);
        r[A_ZM] = ts(-K6_1, X_LS);  r[A_ZM+1] = ts(K8_3, X_LC);
        r[A_ZM+2] = ts(-K24_1, X_B);
        r[A_ZP] = ts(K6_1, X_LS);   r[A_ZP+1] = ts(K8_3, X_LC);
        r[A_ZP+2] = ts(-K24_1, X_B);
      end
      R_D13_1520: begin
        r[A_M1] = ts(K6_1, X_TM);   r[A_M1+1] = ts(-K16_3, X_LRM);
        r[A_P1] = ts(K6_1, X_TP);   r[A_P1+1] = ts(-K16_3, X_LRP);
        r[A_M3] = ts(K18_1, X_TM);  r[A_P3] = ts(K18_1, X_TP);
        r[A_ZM] = ts(-K12_1, X_LS); r[A_ZM+1] = ts(K16_3, X_LC);
        r[A_ZP] = ts(-K12_1, X_LS); r[A_ZP+1] = ts(-K16_3, X_LC);
      end
      R_S11_1650: begin
        r[A_M1] = ts(K1_6, X_LRM);  r[A_P1] = ts(-K1_6, X_LRP);
        r[A_ZM] = ts(-K2_3, X_LC);  r[A_ZM+1] = ts(K6_1, X_B);
        r[A_ZP] = ts(-K2_3, X_LC);  r[A_ZP+1] = ts(K6_1, X_B);
      end
      R_D13_1700: begin
        r[A_M1] = ts(K1_30, X_LRM); r[A_P1] = ts(K1_30, X_LRP);
        r[A_M3] = ts(K9_10, X_LRM); r[A_P3] = ts(K9_10, X_LRP);
        r[A_ZM] = ts(K2_15, X_LC);  r[A_ZP] = ts(-K2_15, X_LC);
      end
      R_D15_1675: begin
        r[A_M1] = ts(-K3_10, X_LRM); r[A_P1] = ts(K3_10, X_LRP);
        r[A_M3] = ts(-K3_5, X_LRM);  r[A_P3] = ts(K3_5, X_LRP);
        r[A_ZM] = ts(K6_5, X_LC);    r[A_ZP] = ts(K6_5, X_LC);
      end
      R_S31_1620: begin
        r[A_M1] = ts(-K3_1, X_TM);  r[A_M1+1] = ts(K1_6, X_LRM);
        r[A_P1] = ts(K3_1, X_TP);   r[A_P1+1] = ts(-K1_6, X_LRP);
        r[A_ZM] = ts(K3_2, X_LS);   r[A_ZM+1] = ts(K1_6, X_LC);
        r[A_ZM+2] = ts(-K3_2, X_B);
        r[A_ZP] = ts(-K3_2, X_LS);  r[A_ZP+1] = ts(K1_6, X_LC);
        r[A_ZP+2] = ts(-K3_2, X_B);
      end
      R_D33_1700: begin
        r[A_M1] = ts(-K3_2, X_TM);  r[A_M1+1] = ts(-K1_3, X_LRM);
        r[A_P1] = ts(-K3_2, X_TP);  r[A_P1+1] = ts(-K1_3, X_LRP);
        r[A_M3] = ts(-K9_2, X_TM);  r[A_P3] = ts(-K9_2, X_TP);
        r[A_ZM] = ts(K3_1, X_LS);   r[A_ZM+1] = ts(K1_3, X_LC);
        r[A_ZP] = ts(K3_1, X_LS);   r[A_ZP+1] = ts(-K1_3, X_LC);
      end
      R_P11_1440: begin
        r[A_M1] = ts(-K25_12, X_L2RM); r[A_P1] = ts(-K25_12, X_L2RP);
        r[A_ZM] = ts(-K3_4, X_L2S);    r[A_ZM+1] = ts(K25_12, X_L2C);
        r[A_ZM+2] = ts(-K25_3, X_LB);
        r[A_ZP] = ts(-K3_4, X_L2S);    r[A_ZP+1] = ts(-K25_12, X_L2C);
        r[A_ZP+2] = ts(K25_3, X_LB);
      end
      R_P33_1600: begin
        r[A_M1] = ts(-K1_6, X_L2RM); r[A_P1] = ts(K1_6, X_L2RP);
        r[A_M3] = ts(-K1_2, X_L2RM); r[A_P3] = ts(K1_2, X_L2RP);
        r[A_ZM] = ts(K2_3, X_L2C);   r[A_ZM+1] = ts(-K8_3, X_LB);
        r[A_ZP] = ts(K2_3, X_L2C);   r[A_ZP+1] = ts(-K8_3, X_LB);
      end
      R_P13_1720: begin
        r[A_M1] = ts(-K27_10, X_LTM); r[A_M1+1] = ts(-K5_3, X_L2RM);
        r[A_P1] = ts(K27_10, X_LTP);  r[A_P1+1] = ts(K5_3, X_L2RP);
        r[A_M3] = ts(K9_10, X_LTM);   r[A_P3] = ts(-K9_10, X_LTP);
        r[A_ZM] = ts(K3_5, X_L2S);    r[A_ZM+1] = ts(-K5_3, X_L2C);
        r[A_ZM+2] = ts(K125_3, X_LB);
        r[A_ZP] = ts(-K3_5, X_L2S);   r[A_ZP+1] = ts(-K5_3, X_L2C);
        r[A_ZP+2] = ts(K125_3, X_LB);
      end
      R_F15_1680: begin
        r[A_M1] = ts(-K9_5, X_LTM);  r[A_M1+1] = ts(K5_2, X_L2RM);
        r[A_P1] = ts(-K9_5, X_LTP);  r[A_P1+1] = ts(K5_2, X_L2RP);
        r[A_M3] = ts(-K18_5, X_LTM); r[A_P3] = ts(-K18_5, X_LTP);
        r[A_ZM] = ts(K9_10, X_L2S);  r[A_ZM+1] = ts(-K5_2, X_L2C);
        r[A_ZP] = ts(K9_10, X_L2S);  r[A_ZP+1] = ts(K5_2, X_L2C);
      end
      R_P31_1910: begin
        r[A_M1] = ts(K1_15, X_L2RM); r[A_P1] = ts(K1_15, X_L2RP);
        r[A_ZM] = ts(K4_15, X_L2C);  r[A_ZM+1] = ts(-K20_3, X_LB);
        r[A_ZP] = ts(-K4_15, X_L2C); r[A_ZP+1] = ts(K20_3, X_LB);
      end
      R_P33_1920: begin
        r[A_M1] = ts(-K1_15, X_L2RM); r[A_P1] = ts(K1_15, X_L2RP);
        r[A_M3] = ts(K1_5, X_L2RM);   r[A_P3] = ts(-K1_5, X_L2RP);
        r[A_ZM] = ts(K4_15, X_L2C);   r[A_ZM+1] = ts(-K20_3, X_LB);
        r[A_ZP] = ts(K4_15, X_L2C);   r[A_ZP+1] = ts(-K20_3, X_LB);
      end
      R_F35_1905: begin
        r[A_M1] = ts(-K1_35, X_L2RM);  r[A_P1] = ts(-K1_35, X_L2RP);
        r[A_M3] = ts(-K18_35, X_L2RM); r[A_P3] = ts(-K18_35, X_L2RP);
        r[A_ZM] = ts(-K4_35, X_L2C);   r[A_ZP] = ts(K4_35, X_L2C);
      end
      R_F37_1950: begin
        r[A_M1] = ts(K6_35, X_L2RM);   r[A_P1] = ts(-K6_35, X_L2RP);
        r[A_M3] = ts(K2_7, X_L2RM);    r[A_P3] = ts(-K2_7, X_L2RP);
        r[A_ZM] = ts(-K24_35, X_L2C);  r[A_ZP] = ts(-K24_35, X_L2C);
      end
      R_P11_1710: begin
        r[A_M1] = ts(K2_3, X_L2RM);  r[A_P1] = ts(K2_3, X_L2RP);
        r[A_ZM] = ts(K3_2, X_L2S);   r[A_ZM+1] = ts(-K2_3, X_L2C);
        r[A_ZM+2] = ts(K8_3, X_LB);
        r[A_ZP] = ts(K3_2, X_L2S);   r[A_ZP+1] = ts(K2_3, X_L2C);
        r[A_ZP+2] = ts(-K8_3, X_LB);
      end
      R_F17_1970: begin
        r[A_M1] = ts(-K3_35, X_L2RM); r[A_P1] = ts(K3_35, X_L2RP);
        r[A_M3] = ts(-K1_7, X_L2RM);  r[A_P3] = ts(K1_7, X_L2RP);
        r[A_ZM] = ts(K6_35, X_L2C);   r[A_ZP] = ts(K6_35, X_L2C);
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

// File: rtl/rsha_front.sv
// rsha_front: input registers and the form factor products (lambda times x,
// lambda squared times x), rounded and saturated to Q8.24.
// depends on rsha_pkg.
module rsha_front import rsha_pkg::*; #(
  parameter int DW = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  res_t                           in_res,
  input  logic signed [DW-1:0]           lambda_q,
  input  logic signed [DW-1:0]           r_minus,
  input  logic signed [DW-1:0]           r_plus,
  input  logic signed [DW-1:0]           t_minus,
  input  logic signed [DW-1:0]           t_plus,
  input  logic signed [DW-1:0]           c_term,
  input  logic signed [DW-1:0]           s_term,
  input  logic signed [DW-1:0]           b_term,
  output logic                           out_valid,
  output res_t                           out_res,
  output logic [NUM_SRC-1:0][DW-1:0]     out_terms
);

  localparam int PW = 2 * DW;
  localparam logic signed [PW:0] HI = {{(DW + 2){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [PW:0] LO = ~HI;
  localparam logic signed [PW:0] HALF = (PW + 1)'(1) <<< (FRAC_BITS - 1);

  function automatic logic signed [DW-1:0] rnd_sat(input logic signed [PW-1:0] p);
    logic signed [PW:0] t;
    t = ((PW + 1)'(p) + HALF) >>> FRAC_BITS;
    if (t > HI) begin
      return HI[DW-1:0];
    end else if (t < LO) begin
      return LO[DW-1:0];
    end
    return t[DW-1:0];
  endfunction

  // stage 1: captured inputs
  logic v1;
  res_t res1;
  logic signed [DW-1:0] lam1, rm1, rp1, tm1, tp1, c1, s1, b1;
  // stage 2: lambda products, full width
  logic v2;
  res_t res2;
  logic signed [PW-1:0] p_ll, p_lrm, p_lrp, p_ltm, p_ltp, p_lc, p_ls, p_lb;
  logic signed [DW-1:0] rm2, rp2, tm2, tp2, c2, s2, b2;
  // stage 3: rounded lambda terms
  logic v3;
  res_t res3;
  logic signed [DW-1:0] l2_3, lrm3, lrp3, ltm3, ltp3, lc3, ls3, lb3;
  logic signed [DW-1:0] rm3, rp3, tm3, tp3, c3, s3, b3;
  // stage 4: lambda squared products
  logic v4;
  res_t res4;
  logic signed [PW-1:0] q_rm, q_rp, q_c, q_s;
  logic signed [DW-1:0] lrm4, lrp4, ltm4, ltp4, lc4, ls4, lb4;
  logic signed [DW-1:0] rm4, rp4, tm4, tp4, c4, b4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    res1 <= in_res;
    lam1 <= lambda_q;
    rm1 <= r_minus;
    rp1 <= r_plus;
    tm1 <= t_minus;
    tp1 <= t_plus;
    c1 <= c_term;
    s1 <= s_term;
    b1 <= b_term;

    res2 <= res1;
    p_ll <= lam1 * lam1;
    p_lrm <= lam1 * rm1;
    p_lrp <= lam1 * rp1;
    p_ltm <= lam1 * tm1;
    p_ltp <= lam1 * tp1;
    p_lc <= lam1 * c1;
    p_ls <= lam1 * s1;
    p_lb <= lam1 * b1;
    rm2 <= rm1;
    rp2 <= rp1;
    tm2 <= tm1;
    tp2 <= tp1;
    c2 <= c1;
    s2 <= s1;
    b2 <= b1;

    res3 <= res2;
    l2_3 <= rnd_sat(p_ll);
    lrm3 <= rnd_sat(p_lrm);
    lrp3 <= rnd_sat(p_lrp);
    ltm3 <= rnd_sat(p_ltm);
    ltp3 <= rnd_sat(p_ltp);
    lc3 <= rnd_sat(p_lc);
    ls3 <= rnd_sat(p_ls);
    lb3 <= rnd_sat(p_lb);
    rm3 <= rm2;
    rp3 <= rp2;
    tm3 <= tm2;
    tp3 <= tp2;
    c3 <= c2;
    s3 <= s2;
    b3 <= b2;

    res4 <= res3;
    q_rm <= l2_3 * rm3;
    q_rp <= l2_3 * rp3;
    q_c <= l2_3 * c3;
    q_s <= l2_3 * s3;
    lrm4 <= lrm3;
    lrp4 <= lrp3;
    ltm4 <= ltm3;
    ltp4 <= ltp3;
    lc4 <= lc3;
    ls4 <= ls3;
    lb4 <= lb3;
    rm4 <= rm3;
    rp4 <= rp3;
    tm4 <= tm3;
    tp4 <= tp3;
    c4 <= c3;
    b4 <= b3;

    out_res <= res4;
    out_terms[X_RM] <= rm4;
    out_terms[X_RP] <= rp4;
    out_terms[X_TM] <= tm4;
    out_terms[X_TP] <= tp4;
    out_terms[X_C] <= c4;
    out_terms[X_B] <= b4;
    out_terms[X_LRM] <= lrm4;
    out_terms[X_LRP] <= lrp4;
    out_terms[X_LTM] <= ltm4;
    out_terms[X_LTP] <= ltp4;
    out_terms[X_LC] <= lc4;
    out_terms[X_LS] <= ls4;
    out_terms[X_LB] <= lb4;
    out_terms[X_L2RM] <= rnd_sat(q_rm);
    out_terms[X_L2RP] <= rnd_sat(q_rp);
    out_terms[X_L2C] <= rnd_sat(q_c);
    out_terms[X_L2S] <= rnd_sat(q_s);
  end

endmodule

// File: rtl/rsha_queue.sv
// rsha_queue: two-entry queue between the product front and the
// coefficient back; status travels as q_stat_t. depends on rsha_pkg.
module rsha_queue import rsha_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output q_stat_t      stat
);

  logic [W-1:0] entry [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic         do_push;
  logic         do_pop;

  assign stat.empty = (cnt == 2'd0);
  assign stat.full  = (cnt == 2'd2);
  assign do_pop  = pop && !stat.empty;
  assign do_push = push && (!stat.full || do_pop);
  assign dout    = entry[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wp] <= din;
    end
  end

endmodule

// File: rtl/rsha_back.sv
// rsha_back: coefficient lookup, coefficient-by-term products and the
// rounded, saturated amplitude sums. depends on rsha_pkg.
module rsha_back import rsha_pkg::*; #(
  parameter int DW = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  res_t                       in_res,
  input  logic [NUM_SRC-1:0][DW-1:0] in_terms,
  output logic                       done,
  output logic                       known,
  output logic signed [DW-1:0]       amp [NUM_AMP]
);

  localparam int MW = COEF_W + DW;
  localparam int SW = MW + 2;
  localparam logic signed [SW-1:0] HI = {{(COEF_W + 3){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [SW-1:0] LO = ~HI;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (COEF_BITS - 1);

  function automatic logic signed [DW-1:0] rnd_sat(input logic signed [SW-1:0] a);
    logic signed [SW-1:0] t;
    t = (a + HALF) >>> COEF_BITS;
    if (t > HI) begin
      return HI[DW-1:0];
    end else if (t < LO) begin
      return LO[DW-1:0];
    end
    return t[DW-1:0];
  endfunction

  row_t                 row;
  logic                 v1, v2;
  logic                 known1, known2;
  coef_t                coef1 [NUM_SLOT];
  logic signed [DW-1:0] term1 [NUM_SLOT];
  logic signed [MW-1:0] prod2 [NUM_SLOT];

  assign row = amp_row(in_res);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    known1 <= (in_res < res_t'(NUM_RES));
    for (int j = 0; j < NUM_SLOT; j++) begin
      coef1[j] <= row[j].coef;
      if (row[j].src < src_t'(NUM_SRC)) begin
        term1[j] <= in_terms[row[j].src];
      end else begin
        term1[j] <= '0;
      end
    end

    known2 <= known1;
    for (int j = 0; j < NUM_SLOT; j++) begin
      prod2[j] <= coef1[j] * term1[j];
    end

    known <= known2;
    for (int a = 0; a < NUM_AMP; a++) begin
      amp[a] <= rnd_sat(SW'(prod2[3*a]) + SW'(prod2[3*a+1]) + SW'(prod2[3*a+2]));
    end
  end

endmodule

// File: rtl/resonance_helicity_amplitudes.sv
// resonance_helicity_amplitudes: top level of the helicity amplitude block.
// depends on rsha_pkg, rsha_front, rsha_queue and rsha_back.
//
//   channel   handshake          payload
//   input     start / busy       resonance, lambda_q, r_minus .. b_term
//   result    done (one cycle)   known, amp_minus1 .. amp_zero_plus
//
// one item per cycle sustained. the front chains two multiplies (lambda squared,
// then times x) and the back adds the coefficient multiply.
// rst is synchronous and clears all valid flags and the queue pointers.
// the back drains the queue every cycle and the receiver cannot stall, so
// busy stays low.
module resonance_helicity_amplitudes import rsha_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [4:0]                   resonance,
  input  logic signed [DATA_WIDTH-1:0] lambda_q,
  input  logic signed [DATA_WIDTH-1:0] r_minus,
  input  logic signed [DATA_WIDTH-1:0] r_plus,
  input  logic signed [DATA_WIDTH-1:0] t_minus,
  input  logic signed [DATA_WIDTH-1:0] t_plus,
  input  logic signed [DATA_WIDTH-1:0] c_term,
  input  logic signed [DATA_WIDTH-1:0] s_term,
  input  logic signed [DATA_WIDTH-1:0] b_term,
  output logic                         done,
  output logic                         known,
  output logic signed [DATA_WIDTH-1:0] amp_minus1,
  output logic signed [DATA_WIDTH-1:0] amp_plus1,
  output logic signed [DATA_WIDTH-1:0] amp_minus3,
  output logic signed [DATA_WIDTH-1:0] amp_plus3,
  output logic signed [DATA_WIDTH-1:0] amp_zero_minus,
  output logic signed [DATA_WIDTH-1:0] amp_zero_plus
);

  localparam int QW = RES_W + NUM_SRC * DATA_WIDTH;

  logic                               f_valid;
  res_t                               f_res;
  logic [NUM_SRC-1:0][DATA_WIDTH-1:0] f_terms;
  logic [QW-1:0]                      q_dout;
  q_stat_t                            q_stat;
  logic signed [DATA_WIDTH-1:0]       amp [NUM_AMP];

  assign busy = q_stat.full;

  rsha_front #(.DW(DATA_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_res    (resonance),
    .lambda_q  (lambda_q),
    .r_minus   (r_minus),
    .r_plus    (r_plus),
    .t_minus   (t_minus),
    .t_plus    (t_plus),
    .c_term    (c_term),
    .s_term    (s_term),
    .b_term    (b_term),
    .out_valid (f_valid),
    .out_res   (f_res),
    .out_terms (f_terms)
  );

  rsha_queue #(.W(QW)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (f_valid),
    .din  ({f_res, f_terms}),
    .pop  (!q_stat.empty),
    .dout (q_dout),
    .stat (q_stat)
  );

  rsha_back #(.DW(DATA_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!q_stat.empty),
    .in_res   (q_dout[QW-1 -: RES_W]),
    .in_terms (q_dout[QW-RES_W-1:0]),
    .done     (done),
    .known    (known),
    .amp      (amp)
  );

  assign amp_minus1     = amp[0];
  assign amp_plus1      = amp[1];
  assign amp_minus3     = amp[2];
  assign amp_plus3      = amp[3];
  assign amp_zero_minus = amp[4];
  assign amp_zero_plus  = amp[5];

endmodule

// File: rtl/rsha_chk.sv
// rsha_chk: port-level checks of the helicity amplitude block, bound to
// the top level. depends on rsha_pkg.
module rsha_chk import rsha_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [4:0]                   resonance,
  input logic                         done,
  input logic                         known,
  input logic signed [DATA_WIDTH-1:0] amp_minus1,
  input logic signed [DATA_WIDTH-1:0] amp_plus1,
  input logic signed [DATA_WIDTH-1:0] amp_minus3,
  input logic signed [DATA_WIDTH-1:0] amp_plus3,
  input logic signed [DATA_WIDTH-1:0] amp_zero_minus,
  input logic signed [DATA_WIDTH-1:0] amp_zero_plus
);

  // every result must follow a matching transfer
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 9))
    else $error("result without matching transfer");

  a_known: assert property (@(posedge clk) disable iff (rst)
    done |-> (known == ($past(resonance, 9) < 5'(NUM_RES))))
    else $error("known flag does not match resonance");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !known) |-> (amp_minus1 == '0 && amp_plus1 == '0 &&
      amp_minus3 == '0 && amp_plus3 == '0 && amp_zero_minus == '0 &&
      amp_zero_plus == '0))
    else $error("unknown resonance with nonzero amplitude");

  // the back drains every cycle, so the front never sees back pressure
  a_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised");

endmodule

bind resonance_helicity_amplitudes rsha_chk #(.DATA_WIDTH(DATA_WIDTH)) u_chk (.*);

// File: test/tb_resonance_helicity_amplitudes.sv
`timescale 1ns / 100ps
// tb_resonance_helicity_amplitudes: self-checking testbench for the helicity amplitude block.
// depends on rsha_pkg and resonance_helicity_amplitudes; the predictor is built here from
// its own coefficient table and integer square root.
module tb_resonance_helicity_amplitudes;
  import rsha_pkg::*;

  typedef enum int {AM1, AP1, AM3, AP3, AZM, AZP} amp_idx_e;

  typedef struct {
    res_t               res;
    logic signed [31:0] lam, rm, rp, tm, tp, c, s, b;
  } form_factors_t;

  typedef struct {
    logic               known;
    logic signed [31:0] amp[6];
  } amplitudes_t;

  logic clk, rst, start, busy, done, known;
  logic [4:0] resonance;
  logic signed [31:0] lambda_q, r_minus, r_plus, t_minus, t_plus, c_term, s_term, b_term;
  logic signed [31:0] amp_minus1, amp_plus1, amp_minus3, amp_plus3;
  logic signed [31:0] amp_zero_minus, amp_zero_plus;

  int   term_num[NUM_RES][6][3];
  int   term_den[NUM_RES][6][3];
  src_t term_src[NUM_RES][6][3];
  int   term_cnt[NUM_RES][6];

  amplitudes_t pending_amps[$];
  int mismatches;
  int n_sent;
  int n_unknown;
  int n_results;

  resonance_helicity_amplitudes #(.DATA_WIDTH(32)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .resonance(resonance),
    .lambda_q(lambda_q), .r_minus(r_minus), .r_plus(r_plus), .t_minus(t_minus),
    .t_plus(t_plus), .c_term(c_term), .s_term(s_term), .b_term(b_term),
    .done(done), .known(known), .amp_minus1(amp_minus1), .amp_plus1(amp_plus1),
    .amp_minus3(amp_minus3), .amp_plus3(amp_plus3), .amp_zero_minus(amp_zero_minus),
    .amp_zero_plus(amp_zero_plus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic add_term(input int r, input int a, input int n, input int d, input src_t s);
    term_num[r][a][term_cnt[r][a]] = n;
    term_den[r][a][term_cnt[r][a]] = d;
    term_src[r][a][term_cnt[r][a]] = s;
    term_cnt[r][a]++;
  endtask

  task automatic build_table();
    foreach (term_cnt[r, a]) begin
      term_cnt[r][a] = 0;
      for (int k = 0; k < 3; k++) begin
        term_num[r][a][k] = 0;
        term_den[r][a][k] = 1;
        term_src[r][a][k] = X_RM;
      end
    end
    add_term(R_P33_1232, AM1, 2, 1, X_RM);   add_term(R_P33_1232, AP1, -2, 1, X_RP);
    add_term(R_P33_1232, AM3, 6, 1, X_RM);   add_term(R_P33_1232, AP3, -6, 1, X_RP);
    add_term(R_P33_1232, AZM, -8, 1, X_C);   add_term(R_P33_1232, AZP, -8, 1, X_C);

    add_term(R_S11_1535, AM1, 12, 1, X_TM);  add_term(R_S11_1535, AM1, 8, 3, X_LRM);
    add_term(R_S11_1535, AP1, -12, 1, X_TP); add_term(R_S11_1535, AP1, -8, 3, X_LRP);
    add_term(R_S11_1535, AZM, -6, 1, X_LS);  add_term(R_S11_1535, AZM, 8, 3, X_LC);
    add_term(R_S11_1535, AZM, -24, 1, X_B);
    add_term(R_S11_1535, AZP, 6, 1, X_LS);   add_term(R_S11_1535, AZP, 8, 3, X_LC);
    add_term(R_S11_1535, AZP, -24, 1, X_B);

    add_term(R_D13_1520, AM1, 6, 1, X_TM);   add_term(R_D13_1520, AM1, -16, 3, X_LRM);
    add_term(R_D13_1520, AP1, 6, 1, X_TP);   add_term(R_D13_1520, AP1, -16, 3, X_LRP);
    add_term(R_D13_1520, AM3, 18, 1, X_TM);  add_term(R_D13_1520, AP3, 18, 1, X_TP);
    add_term(R_D13_1520, AZM, -12, 1, X_LS); add_term(R_D13_1520, AZM, 16, 3, X_LC);
    add_term(R_D13_1520, AZP, -12, 1, X_LS); add_term(R_D13_1520, AZP, -16, 3, X_LC);

    add_term(R_S11_1650, AM1, 1, 6, X_LRM);  add_term(R_S11_1650, AP1, -1, 6, X_LRP);
    add_term(R_S11_1650, AZM, -2, 3, X_LC);  add_term(R_S11_1650, AZM, 6, 1, X_B);
    add_term(R_S11_1650, AZP, -2, 3, X_LC);  add_term(R_S11_1650, AZP, 6, 1, X_B);

    add_term(R_D13_1700, AM1, 1, 30, X_LRM); add_term(R_D13_1700, AP1, 1, 30, X_LRP);
    add_term(R_D13_1700, AM3, 9, 10, X_LRM); add_term(R_D13_1700, AP3, 9, 10, X_LRP);
    add_term(R_D13_1700, AZM, 2, 15, X_LC);  add_term(R_D13_1700, AZP, -2, 15, X_LC);

    add_term(R_D15_1675, AM1, -3, 10, X_LRM); add_term(R_D15_1675, AP1, 3, 10, X_LRP);
    add_term(R_D15_1675, AM3, -3, 5, X_LRM);  add_term(R_D15_1675, AP3, 3, 5, X_LRP);
    add_term(R_D15_1675, AZM, 6, 5, X_LC);    add_term(R_D15_1675, AZP, 6, 5, X_LC);

    add_term(R_S31_1620, AM1, -3, 1, X_TM);  add_term(R_S31_1620, AM1, 1, 6, X_LRM);
    add_term(R_S31_1620, AP1, 3, 1, X_TP);   add_term(R_S31_1620, AP1, -1, 6, X_LRP);
    add_term(R_S31_1620, AZM, 3, 2, X_LS);   add_term(R_S31_1620, AZM, 1, 6, X_LC);
    add_term(R_S31_1620, AZM, -3, 2, X_B);
    add_term(R_S31_1620, AZP, -3, 2, X_LS);  add_term(R_S31_1620, AZP, 1, 6, X_LC);
    add_term(R_S31_1620, AZP, -3, 2, X_B);

    add_term(R_D33_1700, AM1, -3, 2, X_TM);  add_term(R_D33_1700, AM1, -1, 3, X_LRM);
    add_term(R_D33_1700, AP1, -3, 2, X_TP);  add_term(R_D33_1700, AP1, -1, 3, X_LRP);
    add_term(R_D33_1700, AM3, -9, 2, X_TM);  add_term(R_D33_1700, AP3, -9, 2, X_TP);
    add_term(R_D33_1700, AZM, 3, 1, X_LS);   add_term(R_D33_1700, AZM, 1, 3, X_LC);
    add_term(R_D33_1700, AZP, 3, 1, X_LS);   add_term(R_D33_1700, AZP, -1, 3, X_LC);

    add_term(R_P11_1440, AM1, -25, 12, X_L2RM); add_term(R_P11_1440, AP1, -25, 12, X_L2RP);
    add_term(R_P11_1440, AZM, -3, 4, X_L2S);    add_term(R_P11_1440, AZM, 25, 12, X_L2C);
    add_term(R_P11_1440, AZM, -25, 3, X_LB);
    add_term(R_P11_1440, AZP, -3, 4, X_L2S);    add_term(R_P11_1440, AZP, -25, 12, X_L2C);
    add_term(R_P11_1440, AZP, 25, 3, X_LB);

    add_term(R_P33_1600, AM1, -1, 6, X_L2RM); add_term(R_P33_1600, AP1, 1, 6, X_L2RP);
    add_term(R_P33_1600, AM3, -1, 2, X_L2RM); add_term(R_P33_1600, AP3, 1, 2, X_L2RP);
    add_term(R_P33_1600, AZM, 2, 3, X_L2C);   add_term(R_P33_1600, AZM, -8, 3, X_LB);
    add_term(R_P33_1600, AZP, 2, 3, X_L2C);   add_term(R_P33_1600, AZP, -8, 3, X_LB);

    // plus one half uses lambda times t plus here
    add_term(R_P13_1720, AM1, -27, 10, X_LTM); add_term(R_P13_1720, AM1, -5, 3, X_L2RM);
    add_term(R_P13_1720, AP1, 27, 10, X_LTP);  add_term(R_P13_1720, AP1, 5, 3, X_L2RP);
    add_term(R_P13_1720, AM3, 9, 10, X_LTM);   add_term(R_P13_1720, AP3, -9, 10, X_LTP);
    add_term(R_P13_1720, AZM, 3, 5, X_L2S);    add_term(R_P13_1720, AZM, -5, 3, X_L2C);
    add_term(R_P13_1720, AZM, 125, 3, X_LB);
    add_term(R_P13_1720, AZP, -3, 5, X_L2S);   add_term(R_P13_1720, AZP, -5, 3, X_L2C);
    add_term(R_P13_1720, AZP, 125, 3, X_LB);

    add_term(R_F15_1680, AM1, -9, 5, X_LTM);  add_term(R_F15_1680, AM1, 5, 2, X_L2RM);
    add_term(R_F15_1680, AP1, -9, 5, X_LTP);  add_term(R_F15_1680, AP1, 5, 2, X_L2RP);
    add_term(R_F15_1680, AM3, -18, 5, X_LTM); add_term(R_F15_1680, AP3, -18, 5, X_LTP);
    add_term(R_F15_1680, AZM, 9, 10, X_L2S);  add_term(R_F15_1680, AZM, -5, 2, X_L2C);
    add_term(R_F15_1680, AZP, 9, 10, X_L2S);  add_term(R_F15_1680, AZP, 5, 2, X_L2C);

    add_term(R_P31_1910, AM1, 1, 15, X_L2RM); add_term(R_P31_1910, AP1, 1, 15, X_L2RP);
    add_term(R_P31_1910, AZM, 4, 15, X_L2C);  add_term(R_P31_1910, AZM, -20, 3, X_LB);
    add_term(R_P31_1910, AZP, -4, 15, X_L2C); add_term(R_P31_1910, AZP, 20, 3, X_LB);

    add_term(R_P33_1920, AM1, -1, 15, X_L2RM); add_term(R_P33_1920, AP1, 1, 15, X_L2RP);
    add_term(R_P33_1920, AM3, 1, 5, X_L2RM);   add_term(R_P33_1920, AP3, -1, 5, X_L2RP);
    add_term(R_P33_1920, AZM, 4, 15, X_L2C);   add_term(R_P33_1920, AZM, -20, 3, X_LB);
    add_term(R_P33_1920, AZP, 4, 15, X_L2C);   add_term(R_P33_1920, AZP, -20, 3, X_LB);

    add_term(R_F35_1905, AM1, -1, 35, X_L2RM);  add_term(R_F35_1905, AP1, -1, 35, X_L2RP);
    add_term(R_F35_1905, AM3, -18, 35, X_L2RM); add_term(R_F35_1905, AP3, -18, 35, X_L2RP);
    add_term(R_F35_1905, AZM, -4, 35, X_L2C);   add_term(R_F35_1905, AZP, 4, 35, X_L2C);

    add_term(R_F37_1950, AM1, 6, 35, X_L2RM);   add_term(R_F37_1950, AP1, -6, 35, X_L2RP);
    add_term(R_F37_1950, AM3, 2, 7, X_L2RM);    add_term(R_F37_1950, AP3, -2, 7, X_L2RP);
    add_term(R_F37_1950, AZM, -24, 35, X_L2C);  add_term(R_F37_1950, AZP, -24, 35, X_L2C);

    add_term(R_P11_1710, AM1, 2, 3, X_L2RM);  add_term(R_P11_1710, AP1, 2, 3, X_L2RP);
    add_term(R_P11_1710, AZM, 3, 2, X_L2S);   add_term(R_P11_1710, AZM, -2, 3, X_L2C);
    add_term(R_P11_1710, AZM, 8, 3, X_LB);
    add_term(R_P11_1710, AZP, 3, 2, X_L2S);   add_term(R_P11_1710, AZP, 2, 3, X_L2C);
    add_term(R_P11_1710, AZP, -8, 3, X_LB);

    add_term(R_F17_1970, AM1, -3, 35, X_L2RM); add_term(R_F17_1970, AP1, 3, 35, X_L2RP);
    add_term(R_F17_1970, AM3, -1, 7, X_L2RM);  add_term(R_F17_1970, AP3, 1, 7, X_L2RP);
    add_term(R_F17_1970, AZM, 6, 35, X_L2C);   add_term(R_F17_1970, AZP, 6, 35, X_L2C);
  endtask

  // largest r with r*r <= v, found bit by bit from the top
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // sqrt(|n|/d) in Q4.28 with the sign of n
  function automatic logic signed [63:0] sqrt_ratio(input int n, input int d);
    logic [63:0] mag;
    logic signed [63:0] root;
    if (n == 0) return 0;
    mag  = (n < 0) ? -n : n;
    root = floor_root((mag << 56) / d);
    return (n < 0) ? -root : root;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [79:0] v);
    if (v > 80'sd2147483647) return 32'sh7fffffff;
    if (v < -80'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] q24_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [79:0] p;
    p = 80'(a) * 80'(b);
    p = (p + 80'sd8388608) >>> 24;
    return clamp32(p);
  endfunction

  function automatic amplitudes_t helicity_amps(input form_factors_t f);
    amplitudes_t        o;
    logic signed [31:0] term[NUM_SRC];
    logic signed [31:0] l2;
    logic signed [79:0] acc;
    o.known = 1'b0;
    foreach (o.amp[a]) o.amp[a] = '0;
    if (f.res >= NUM_RES) return o;
    l2 = q24_mul(f.lam, f.lam);
    term[X_RM] = f.rm;  term[X_RP] = f.rp;  term[X_TM] = f.tm;
    term[X_TP] = f.tp;  term[X_C] = f.c;    term[X_B] = f.b;
    term[X_LRM] = q24_mul(f.lam, f.rm);  term[X_LRP] = q24_mul(f.lam, f.rp);
    term[X_LTM] = q24_mul(f.lam, f.tm);  term[X_LTP] = q24_mul(f.lam, f.tp);
    term[X_LC] = q24_mul(f.lam, f.c);    term[X_LS] = q24_mul(f.lam, f.s);
    term[X_LB] = q24_mul(f.lam, f.b);
    term[X_L2RM] = q24_mul(l2, f.rm);    term[X_L2RP] = q24_mul(l2, f.rp);
    term[X_L2C] = q24_mul(l2, f.c);      term[X_L2S] = q24_mul(l2, f.s);
    o.known = 1'b1;
    for (int a = 0; a < 6; a++) begin
      acc = '0;
      for (int k = 0; k < term_cnt[f.res][a]; k++)
        acc += 80'(sqrt_ratio(term_num[f.res][a][k], term_den[f.res][a][k]))
               * 80'(term[term_src[f.res][a][k]]);
      o.amp[a] = clamp32((acc + 80'sd134217728) >>> 28);
    end
    return o;
  endfunction

  // one transfer; start stays high afterwards until the caller idles
  task automatic send_item(input form_factors_t f);
    start     <= 1'b1;
    resonance <= f.res;
    lambda_q  <= f.lam;  r_minus <= f.rm;  r_plus <= f.rp;  t_minus <= f.tm;
    t_plus    <= f.tp;   c_term  <= f.c;   s_term <= f.s;   b_term  <= f.b;
    do @(posedge clk); while (busy);
    pending_amps.push_back(helicity_amps(f));
    n_sent++;
    if (f.res >= NUM_RES) n_unknown++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_amps.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_factor();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'(int'($urandom_range(0, 3)) - 1);
      3, 4, 5: return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic form_factors_t rand_item();
    form_factors_t f;
    f.res = ($urandom_range(0, 9) == 0) ? res_t'($urandom_range(NUM_RES, 31))
                                       : res_t'($urandom_range(0, NUM_RES - 1));
    f.lam = rand_factor();  f.rm = rand_factor();  f.rp = rand_factor();
    f.tm  = rand_factor();  f.tp = rand_factor();  f.c  = rand_factor();
    f.s   = rand_factor();  f.b  = rand_factor();
    return f;
  endfunction

  task automatic test_directed();
    form_factors_t f;
    // every resonance with one-ish values, then unknown codes, rail, zero and minus-one factors
    for (int r = 0; r < NUM_RES; r++) begin
      f.res = res_t'(r);
      f.lam = 32'sh0100_0000; f.rm = 32'sh0080_0000; f.rp = -32'sh0120_0000;
      f.tm = 32'sh0200_0000;  f.tp = -32'sh0030_0000; f.c = 32'sh0155_5555;
      f.s = -32'sh00aa_aaab;  f.b = 32'sh0033_3333;
      send_item(f);
    end
    f.res = res_t'(NUM_RES);
    send_item(f);
    f.res = 5'd31;
    f.lam = 32'sh7fffffff; f.rm = 32'sh7fffffff; f.rp = 32'sh80000000;
    f.tm = 32'sh80000000;  f.tp = 32'sh7fffffff; f.c = 32'sh80000000;
    f.s = 32'sh7fffffff;   f.b = 32'sh80000000;
    send_item(f);
    f.res = R_P13_1720;    send_item(f);
    f.lam = 32'sh80000000; f.res = R_P11_1440; send_item(f);
    f.lam = '0; f.rm = '0; f.rp = '0; f.tm = '0; f.tp = '0; f.c = '0; f.s = '0; f.b = '0;
    f.res = R_P33_1232;    send_item(f);
    f.lam = -32'sd1; f.rm = -32'sd1; f.rp = -32'sd1; f.tm = -32'sd1; f.tp = -32'sd1;
    f.c = -32'sd1;   f.s = -32'sd1;  f.b = -32'sd1;
    f.res = R_F17_1970;    send_item(f);
    drain();
  endtask

  task automatic test_random(input int n_items, input int gap_pct);
    for (int i = 0; i < n_items; i++) begin
      send_item(rand_item());
      // occasional stretches without gaps even in the idling phases
      if ($urandom_range(0, 99) < gap_pct && (i % 200) < 150)
        idle_cycles($urandom_range(1, 4));
    end
    drain();
  endtask

  always @(posedge clk) begin
    amplitudes_t want;
    logic signed [31:0] got[6];
    logic bad;
    if (!rst && done) begin
      n_results++;
      got = '{amp_minus1, amp_plus1, amp_minus3, amp_plus3, amp_zero_minus, amp_zero_plus};
      if (pending_amps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result transfer with nothing expected at %0t", $realtime);
      end else begin
        want = pending_amps.pop_front();
        bad = (known !== want.known);
        for (int a = 0; a < 6; a++)
          if (got[a] !== want.amp[a]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: known exp %0b got %0b", $realtime, want.known, known);
            for (int a = 0; a < 6; a++)
              $display("  amp %0d exp %h got %h", a, want.amp[a], got[a]);
          end
        end
      end
    end
  end

  initial begin
    start = 1'b0;  rst = 1'b1;  resonance = '0;
    lambda_q = '0; r_minus = '0; r_plus = '0; t_minus = '0; t_plus = '0;
    c_term = '0;   s_term = '0;  b_term = '0;
    mismatches = 0; n_sent = 0; n_unknown = 0; n_results = 0;
    build_table();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(700, 22);
    test_random(700, 59);
    test_random(600, 0);
    if (pending_amps.size() != 0) mismatches++;
    $display("sent %0d items (%0d with unrecognized resonance), checked %0d results",
             n_sent, n_unknown, n_results);
    $display("covered all 18 resonances, rail and zero factors, and back-to-back transfers");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
